// ===== src/cfde_pkg.sv =====
`default_nettype none

package cfde_pkg;

   // frame layout
   localparam int WIN_LEN     = 14;
   localparam int STORE_LEN   = WIN_LEN - 1;
   localparam int FILL_W      = 4;
   localparam int POS_CR_HEAD = 0;
   localparam int POS_LF_HEAD = 1;
   localparam int POS_DOT     = 8;
   localparam int POS_CR_TAIL = 12;
   localparam int POS_LF_TAIL = 13;
   localparam int FIELD_FIRST = 3;
   localparam int FIELD_LEN   = 9;

   // character codes
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // counters and number widths
   localparam logic [7:0] SKIP_MAX = 8'hff;
   localparam int INT_DIGITS  = 5;
   localparam int FRAC_DIGITS = 3;
   localparam int DEC_DIGITS  = INT_DIGITS + FRAC_DIGITS;
   localparam int MAG_W       = 27;
   localparam int VALUE_W     = 28;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 28'sd99999999;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = -28'sd99999999;

   // weight of each decimal digit, least significant first
   localparam logic [MAG_W-1:0] DEC_WEIGHT [DEC_DIGITS] = '{
      27'd1, 27'd10, 27'd100, 27'd1000, 27'd10000,
      27'd100000, 27'd1000000, 27'd10000000
   };

   // text field of a matched frame, handed from the window to the scanner
   typedef struct packed {
      logic [FIELD_LEN-1:0][7:0] text;
      logic [7:0]                skipped;
   } frame_type;

   // scanned number: sign and eight decimal digits, least significant first
   typedef struct packed {
      logic                       negative;
      logic [DEC_DIGITS-1:0][3:0] digits;
      logic [7:0]                 skipped;
   } decimal_type;

endpackage

`default_nettype wire

// ===== src/cfde_window.sv =====
`default_nettype none

module cfde_window (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            in_byte,
   output logic                  frame_valid,
   input  logic                  frame_ready,
   output cfde_pkg::frame_type   frame
);

   logic [7:0]                    win_ff [cfde_pkg::STORE_LEN];
   logic [7:0]                    win_in [cfde_pkg::STORE_LEN];
   logic [cfde_pkg::FILL_W-1:0]   fill_ff;
   logic [cfde_pkg::FILL_W-1:0]   fill_in;
   logic [7:0]                    skip_ff;
   logic [7:0]                    skip_in;
   logic                          frame_valid_ff;
   logic                          frame_valid_in;
   cfde_pkg::frame_type           frame_ff;
   cfde_pkg::frame_type           frame_in;
   logic [7:0]                    full_win [cfde_pkg::WIN_LEN];
   logic                          window_full;
   logic                          match;
   logic                          accept;

   // full 14 byte view: stored bytes plus the incoming word
   always_comb begin
      for (int i = 0; i < cfde_pkg::STORE_LEN; i++) begin
         full_win[i] = win_ff[i];
      end
      full_win[cfde_pkg::STORE_LEN] = in_byte;
   end

   assign window_full = (fill_ff == cfde_pkg::FILL_W'(cfde_pkg::STORE_LEN));
   assign match = window_full
      && (full_win[cfde_pkg::POS_CR_HEAD] == cfde_pkg::CH_CR)
      && (full_win[cfde_pkg::POS_LF_HEAD] == cfde_pkg::CH_LF)
      && (full_win[cfde_pkg::POS_DOT]     == cfde_pkg::CH_DOT)
      && (full_win[cfde_pkg::POS_CR_TAIL] == cfde_pkg::CH_CR)
      && (full_win[cfde_pkg::POS_LF_TAIL] == cfde_pkg::CH_LF);

   assign in_ready = !frame_valid_ff || frame_ready;
   assign accept   = in_valid && in_ready;

   // window fill, realign and frame capture
   always_comb begin
      win_in         = win_ff;
      fill_in        = fill_ff;
      skip_in        = skip_ff;
      frame_valid_in = frame_valid_ff && !frame_ready;
      frame_in       = frame_ff;
      if (accept) begin
         priority if (!window_full) begin
            win_in[fill_ff] = in_byte;
            fill_in         = fill_ff + 1'b1;
         end else if (match) begin
            fill_in        = '0;
            skip_in        = '0;
            frame_valid_in = 1'b1;
            for (int i = 0; i < cfde_pkg::FIELD_LEN; i++) begin
               frame_in.text[i] = full_win[cfde_pkg::FIELD_FIRST + i];
            end
            frame_in.skipped = skip_ff;
         end else begin
            // drop the oldest byte
            for (int i = 0; i < cfde_pkg::STORE_LEN; i++) begin
               win_in[i] = full_win[i + 1];
            end
            if (skip_ff != cfde_pkg::SKIP_MAX) begin
               skip_in = skip_ff + 1'b1;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= '0;
         skip_ff        <= '0;
         frame_valid_ff <= 1'b0;
      end else begin
         fill_ff        <= fill_in;
         skip_ff        <= skip_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      frame_ff <= frame_in;
   end

   assign frame_valid = frame_valid_ff;
   assign frame       = frame_ff;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cfde_pkg::FILL_W'(cfde_pkg::STORE_LEN))
      else $error("window fill above 13");

   a_match_clears: assert property (@(posedge clock) disable iff (reset)
      accept && match |=> fill_ff == '0 && skip_ff == '0 && frame_valid_ff)
      else $error("frame match did not clear window and counter");

   a_miss_realigns: assert property (@(posedge clock) disable iff (reset)
      accept && window_full && !match
      |=> fill_ff == cfde_pkg::FILL_W'(cfde_pkg::STORE_LEN) && skip_ff != '0)
      else $error("mismatch did not realign window");

endmodule

`default_nettype wire

// ===== src/cfde_scan.sv =====
`default_nettype none

module cfde_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cfde_pkg::frame_type   frame,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cfde_pkg::decimal_type decimal
);

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_INT,
      PH_FRAC,
      PH_DONE
   } scan_phase_type;

   logic                  valid_ff;
   logic                  valid_in;
   cfde_pkg::decimal_type dec_ff;
   cfde_pkg::decimal_type dec_in;
   logic                  accept;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == cfde_pkg::CH_SPACE) || (c >= cfde_pkg::CH_TAB && c <= cfde_pkg::CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= cfde_pkg::CH_ZERO) && (c <= cfde_pkg::CH_NINE);
   endfunction

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // walk the nine text bytes: blanks, sign, integer digits, dot, fraction
   always_comb begin
      scan_phase_type                     phase;
      logic [7:0]                         c;
      logic                               negative;
      logic [cfde_pkg::INT_DIGITS-1:0][3:0]  int_dig;
      logic [cfde_pkg::FRAC_DIGITS-1:0][3:0] frac_dig;
      logic [1:0]                         frac_cnt;
      phase    = PH_LEAD;
      negative = 1'b0;
      int_dig  = '0;
      frac_dig = '0;
      frac_cnt = '0;
      for (int i = 0; i < cfde_pkg::FIELD_LEN; i++) begin
         c = frame.text[i];
         unique case (phase)
            PH_LEAD: begin
               priority if (is_blank(c)) begin
                  phase = PH_LEAD;
               end else if (c == cfde_pkg::CH_PLUS || c == cfde_pkg::CH_MINUS) begin
                  negative = (c == cfde_pkg::CH_MINUS);
                  phase    = PH_INT;
               end else if (is_digit(c)) begin
                  int_dig = {int_dig[cfde_pkg::INT_DIGITS-2:0], c[3:0]};
                  phase   = PH_INT;
               end else if (c == cfde_pkg::CH_DOT) begin
                  phase = PH_FRAC;
               end else begin
                  phase = PH_DONE;
               end
            end
            PH_INT: begin
               priority if (is_digit(c)) begin
                  int_dig = {int_dig[cfde_pkg::INT_DIGITS-2:0], c[3:0]};
               end else if (c == cfde_pkg::CH_DOT) begin
                  phase = PH_FRAC;
               end else begin
                  phase = PH_DONE;
               end
            end
            PH_FRAC: begin
               if (is_digit(c)) begin
                  // digits past the third are dropped
                  if (frac_cnt < 2'(cfde_pkg::FRAC_DIGITS)) begin
                     frac_dig[frac_cnt] = c[3:0];
                     frac_cnt           = frac_cnt + 1'b1;
                  end
               end else begin
                  phase = PH_DONE;
               end
            end
            PH_DONE: begin
               phase = PH_DONE;
            end
            default: begin
               phase = PH_DONE;
            end
         endcase
      end
      dec_in.negative = negative;
      dec_in.digits[cfde_pkg::DEC_DIGITS-1:cfde_pkg::FRAC_DIGITS] = int_dig;
      for (int j = 0; j < cfde_pkg::FRAC_DIGITS; j++) begin
         dec_in.digits[cfde_pkg::FRAC_DIGITS-1-j] = frac_dig[j];
      end
      dec_in.skipped = frame.skipped;
   end

   assign valid_in = accept || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dec_ff <= dec_in;
      end
   end

   assign out_valid = valid_ff;
   assign decimal   = dec_ff;

endmodule

`default_nettype wire

// ===== src/cfde_accum.sv =====
`default_nettype none

module cfde_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  cfde_pkg::decimal_type               decimal,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cfde_pkg::VALUE_W-1:0] rsp_value_thousandths,
   output logic [7:0]                          rsp_skipped_bytes
);

   logic                                mag_valid_ff;
   logic                                mag_valid_in;
   logic [cfde_pkg::MAG_W-1:0]          mag_ff;
   logic [cfde_pkg::MAG_W-1:0]          mag_in;
   logic                                neg_ff;
   logic [7:0]                          mag_skip_ff;
   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic signed [cfde_pkg::VALUE_W-1:0] value_ff;
   logic signed [cfde_pkg::VALUE_W-1:0] value_in;
   logic [7:0]                          skip_ff;
   logic                                out_free;
   logic                                accept;
   logic                                advance;

   assign out_free = !out_valid_ff || rsp_ready;
   assign in_ready = !mag_valid_ff || out_free;
   assign accept   = in_valid && in_ready;
   assign advance  = mag_valid_ff && out_free;

   // magnitude from the decimal digits, constant weights
   always_comb begin
      mag_in = '0;
      for (int k = 0; k < cfde_pkg::DEC_DIGITS; k++) begin
         mag_in = mag_in + cfde_pkg::MAG_W'(decimal.digits[k]) * cfde_pkg::DEC_WEIGHT[k];
      end
   end

   // apply sign
   always_comb begin
      if (neg_ff) begin
         value_in = cfde_pkg::VALUE_W'(0) - $signed({1'b0, mag_ff});
      end else begin
         value_in = $signed({1'b0, mag_ff});
      end
   end

   assign mag_valid_in = accept || (mag_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mag_valid_ff <= mag_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mag_ff      <= mag_in;
         neg_ff      <= decimal.negative;
         mag_skip_ff <= decimal.skipped;
      end
      if (advance) begin
         value_ff <= value_in;
         skip_ff  <= mag_skip_ff;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_value_thousandths = value_ff;
   assign rsp_skipped_bytes     = skip_ff;

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> value_ff <= cfde_pkg::VALUE_MAX && value_ff >= cfde_pkg::VALUE_MIN)
      else $error("result value out of range");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      mag_valid_ff && !out_free |=> mag_valid_ff && $stable(mag_ff) && $stable(neg_ff))
      else $error("magnitude stage lost a word while blocked");

endmodule

`default_nettype wire

// ===== src/crlf_frame_decimal_extractor.sv =====
`default_nettype none

// Takes one serial byte per word and looks for a 14 byte frame of the form
// CR LF, an unchecked byte, nine text bytes with a dot at frame byte 8, CR
// LF. The text is read like atof (leading blanks, optional sign, digits,
// dot, up to three fraction digits, no exponent) and delivered as a signed
// value in thousandths, with the count of bytes dropped while hunting for
// the frame (saturating at 255). One byte is accepted every cycle; req_ready
// drops only when the four result registers (frame, digit scan, magnitude,
// output) are all full and the consumer holds off. Results pass them in turn.
module crlf_frame_decimal_extractor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cfde_pkg::VALUE_W-1:0] rsp_value_thousandths,
   output logic [7:0]                          rsp_skipped_bytes
);

   logic                  frame_valid;
   logic                  frame_ready;
   cfde_pkg::frame_type   frame;
   logic                  dec_valid;
   logic                  dec_ready;
   cfde_pkg::decimal_type decimal;

   // byte window and frame detection
   cfde_window u_window (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_byte     (req_rx_byte),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame)
   );

   // text scan into digits
   cfde_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frame_valid),
      .in_ready  (frame_ready),
      .frame     (frame),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .decimal   (decimal)
   );

   // digits to signed value
   cfde_accum u_accum (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (dec_valid),
      .in_ready              (dec_ready),
      .decimal               (decimal),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_value_thousandths (rsp_value_thousandths),
      .rsp_skipped_bytes     (rsp_skipped_bytes)
   );

endmodule

`default_nettype wire
